// ===== sv/csvft_pkg.sv =====
// Shared types and byte codes for the CSV field tokenizer.
package csvft_pkg;

    localparam logic [7:0] BYTE_COMMA = 8'd44;
    localparam logic [7:0] BYTE_QUOTE = 8'd34;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'd32;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELD_LENGTH = 1'd1;

    localparam int CFG_DATA_W   = 13;
    localparam int COL_IDX_W    = 7;
    localparam int LEN_CFG_W    = 13;

    localparam logic [COL_IDX_W-1:0] EXPECTED_COLUMNS_RESET = 7'd1;
    localparam logic [LEN_CFG_W-1:0] MAX_FIELD_LENGTH_RESET = 13'd256;

    typedef enum logic [1:0] {
        MODE_START      = 2'd0,
        MODE_PLAIN      = 2'd1,
        MODE_QUOTED     = 2'd2,
        MODE_QUOTE_SEEN = 2'd3
    } parse_mode_t;

endpackage

// ===== sv/csv_field_tokenizer.sv =====
// Byte-serial CSV splitter that emits field bytes with field and row markers.
//
// The slave channel takes one word per cycle while s_tready is high: s_tdata
// is one raw byte of CSV text and s_tlast marks the end of the data, which
// closes any open field and row while the byte itself is ignored. Each
// accepted word produces zero or one result word on the master channel. A
// result carries a content byte or a field end (or both, when a field is
// cut at the length limit), and m_tlast marks the end of a row.
// The parse state updates in the cycle a word is accepted and the result is
// held in an output register, so throughput is one word per cycle while the
// receiver keeps up. The input stays ready while the output register is
// empty or is being taken in the same cycle; when the receiver stalls with
// a result waiting, s_tready drops until m_tready returns.
// The configuration channel writes expected_columns (index 0) or
// max_field_length (index 1); it is always ready and should be used only
// while no word is in flight. Reset returns the parser to the start of a
// field in a new row, restores the register defaults and empties the output.
module csv_field_tokenizer
    import csvft_pkg::*;
#(
    parameter int MAX_COLUMNS     = 64,
    parameter int MAX_FIELD_BYTES = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] input_byte
    input  logic                  s_tlast,   // end_of_data
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] out_char, [8] field_end, [15:9] column_index,
    // [16] field_overflow, [17] row_valid, [23:18] zero
    output logic [23:0]           m_tdata,
    output logic                  m_tuser,   // char_valid
    output logic                  m_tlast,   // row_end
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CCW  = $clog2(MAX_COLUMNS + 1);
    localparam int CMPW = ((CCW > COL_IDX_W) ? CCW : COL_IDX_W) + 1;
    localparam int FLW  = $clog2(MAX_FIELD_BYTES + 1);
    localparam int LCW  = ((FLW > LEN_CFG_W) ? FLW : LEN_CFG_W) + 1;
    localparam logic [CMPW-1:0] MAX_COL_C   = CMPW'(MAX_COLUMNS);
    localparam logic [LCW-1:0]  MAX_BYTES_C = LCW'(MAX_FIELD_BYTES);

    logic [COL_IDX_W-1:0] expected_columns_reg;
    logic [LEN_CFG_W-1:0] max_field_length_reg;
    parse_mode_t          mode_reg, mode_next;
    logic [FLW-1:0]       field_length_reg, field_length_next;
    logic [CCW-1:0]       column_count_reg, column_count_next;

    logic                 out_valid_reg;
    logic [7:0]           out_char_reg, out_char_next;
    logic                 char_valid_reg, char_valid_next;
    logic                 field_end_reg, field_end_next;
    logic                 row_end_reg, row_end_next;
    logic [COL_IDX_W-1:0] column_index_reg;
    logic                 overflow_reg, overflow_next;
    logic                 row_valid_reg, row_valid_next;

    logic                 accept;
    logic                 emit;
    logic                 is_newline;
    logic                 content;
    logic [LCW-1:0]       limit;
    logic [LCW-1:0]       length_inc;
    logic [CMPW-1:0]      col_ext;
    logic                 end_f;
    logic                 end_row;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign is_newline = (s_tdata == BYTE_LF) || (s_tdata == BYTE_CR);
    assign col_ext    = CMPW'(column_count_reg);
    assign length_inc = LCW'(field_length_reg) + LCW'(1);
    assign limit      = (LCW'(max_field_length_reg) > MAX_BYTES_C) ?
                        MAX_BYTES_C : LCW'(max_field_length_reg);

    always_comb begin
        mode_next         = mode_reg;
        field_length_next = field_length_reg;
        column_count_next = column_count_reg;
        emit              = 1'b0;
        content           = 1'b0;
        end_f             = 1'b0;
        end_row           = 1'b0;
        out_char_next     = '0;
        char_valid_next   = 1'b0;
        field_end_next    = 1'b0;
        row_end_next      = 1'b0;
        overflow_next     = 1'b0;
        row_valid_next    = 1'b0;

        if (s_tlast) begin
            if (!(mode_reg == MODE_START && column_count_reg == '0)) begin
                emit    = 1'b1;
                end_f   = 1'b1;
                end_row = 1'b1;
            end
        end else begin
            unique case (mode_reg)
                MODE_START: begin
                    if (s_tdata == BYTE_QUOTE) begin
                        mode_next = MODE_QUOTED;
                    end else if (s_tdata == BYTE_COMMA || is_newline) begin
                        emit    = 1'b1;
                        end_f   = 1'b1;
                        end_row = is_newline;
                    end else if (s_tdata != BYTE_SPACE) begin
                        mode_next = MODE_PLAIN;
                        content   = 1'b1;
                    end
                end
                MODE_PLAIN: begin
                    if (s_tdata == BYTE_COMMA || is_newline) begin
                        emit    = 1'b1;
                        end_f   = 1'b1;
                        end_row = is_newline;
                    end else begin
                        content = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (s_tdata == BYTE_QUOTE) begin
                        mode_next = MODE_QUOTE_SEEN;
                    end else begin
                        content = 1'b1;
                    end
                end
                MODE_QUOTE_SEEN: begin
                    if (s_tdata == BYTE_QUOTE) begin
                        mode_next = MODE_QUOTED;
                        content   = 1'b1;
                    end else begin
                        emit    = 1'b1;
                        end_f   = 1'b1;
                        end_row = is_newline;
                    end
                end
                default: begin
                    mode_next = MODE_START;
                end
            endcase
        end

        if (content) begin
            emit              = 1'b1;
            out_char_next     = s_tdata;
            char_valid_next   = 1'b1;
            field_length_next = FLW'(length_inc);
            if (length_inc >= limit) begin
                overflow_next = 1'b1;
                end_f         = 1'b1;
            end
        end

        if (end_f) begin
            field_end_next    = 1'b1;
            mode_next         = MODE_START;
            field_length_next = '0;
            if (end_row) begin
                row_end_next      = 1'b1;
                row_valid_next    = (col_ext < MAX_COL_C) &&
                                    (col_ext + CMPW'(1) == CMPW'(expected_columns_reg));
                column_count_next = '0;
            end else if (col_ext < MAX_COL_C) begin
                column_count_next = CCW'(col_ext + CMPW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_columns_reg <= EXPECTED_COLUMNS_RESET;
            max_field_length_reg <= MAX_FIELD_LENGTH_RESET;
            mode_reg             <= MODE_START;
            field_length_reg     <= '0;
            column_count_reg     <= '0;
            out_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_EXPECTED_COLUMNS: expected_columns_reg <= cfg_data[COL_IDX_W-1:0];
                    REG_MAX_FIELD_LENGTH: max_field_length_reg <= cfg_data[LEN_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                mode_reg         <= mode_next;
                field_length_reg <= field_length_next;
                column_count_reg <= column_count_next;
            end
            if (accept && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            out_char_reg     <= out_char_next;
            char_valid_reg   <= char_valid_next;
            field_end_reg    <= field_end_next;
            row_end_reg      <= row_end_next;
            column_index_reg <= col_ext[COL_IDX_W-1:0];
            overflow_reg     <= overflow_next;
            row_valid_reg    <= row_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, row_valid_reg, overflow_reg, column_index_reg,
                       field_end_reg, out_char_reg};
    assign m_tuser  = char_valid_reg;
    assign m_tlast  = row_end_reg;

endmodule

// ===== verif/csv_field_tokenizer_tb.sv =====
// Self-checking testbench for the CSV field tokenizer with a built-in parse predictor.
module csv_field_tokenizer_tb;
    import csvft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS    = 64;
    localparam int MAX_FIELD   = 4096;
    localparam int CYCLE_LIMIT = 600000;
    localparam int N_PHASES    = 8;

    typedef struct packed {
        logic [7:0] raw;
        logic       eod;
    } word_t;

    typedef struct packed {
        logic [5:0] pad;
        logic       row_ok;
        logic       overflow;
        logic [6:0] column;
        logic       field_end;
        logic [7:0] ch;
        logic       ch_valid;
        logic       row_end;
    } token_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [23:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    word_t       text_q[$];
    token_t      token_q[$];
    int          words_queued = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    parse_mode_t mode = MODE_START;
    int          field_len = 0;
    int          col_cnt = 0;
    int          exp_cols = 1;
    int          max_len = 256;

    int          burst_left = 0;
    int          gap_left = 0;
    int          rx_mode = 0;
    int          rx_left = 0;

    int phase_cols[N_PHASES] = '{3, 64, 0, 127, 5, 2, 1, 4};
    int phase_len[N_PHASES]  = '{8, 2, 1, 0, 4096, 8191, 2, 256};

    csv_field_tokenizer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic close_field(inout token_t tok, input bit row);
        bit ok;
        tok.field_end = 1'b1;
        tok.column    = 7'(col_cnt);
        if (row) begin
            ok = (col_cnt < MAX_COLS) && (col_cnt + 1 == exp_cols);
            tok.row_end = 1'b1;
            tok.row_ok  = ok;
            col_cnt     = 0;
        end else if (col_cnt < MAX_COLS) begin
            col_cnt++;
        end
        mode      = MODE_START;
        field_len = 0;
    endtask

    task automatic take_content(inout token_t tok, input logic [7:0] c);
        int limit;
        limit        = (max_len > MAX_FIELD) ? MAX_FIELD : max_len;
        tok.ch       = c;
        tok.ch_valid = 1'b1;
        field_len++;
        if (field_len >= limit) begin
            tok.overflow = 1'b1;
            close_field(tok, 1'b0);
        end
    endtask

    task automatic tokenize_word(input logic [7:0] c, input logic eod);
        token_t tok;
        bit     nl;
        bit     emits;
        tok        = '0;
        tok.column = 7'(col_cnt);
        nl         = (c == BYTE_LF) || (c == BYTE_CR);
        emits      = 1'b1;
        if (eod) begin
            if (mode == MODE_START && col_cnt == 0)
                emits = 1'b0;
            else
                close_field(tok, 1'b1);
        end else begin
            case (mode)
                MODE_START: begin
                    if (c == BYTE_SPACE) begin
                        emits = 1'b0;
                    end else if (c == BYTE_QUOTE) begin
                        mode  = MODE_QUOTED;
                        emits = 1'b0;
                    end else if (c == BYTE_COMMA || nl) begin
                        close_field(tok, nl);
                    end else begin
                        mode = MODE_PLAIN;
                        take_content(tok, c);
                    end
                end
                MODE_PLAIN: begin
                    if (c == BYTE_COMMA || nl)
                        close_field(tok, nl);
                    else
                        take_content(tok, c);
                end
                MODE_QUOTED: begin
                    if (c == BYTE_QUOTE) begin
                        mode  = MODE_QUOTE_SEEN;
                        emits = 1'b0;
                    end else begin
                        take_content(tok, c);
                    end
                end
                default: begin
                    if (c == BYTE_QUOTE) begin
                        mode = MODE_QUOTED;
                        take_content(tok, BYTE_QUOTE);
                    end else begin
                        close_field(tok, nl);
                    end
                end
            endcase
        end
        if (emits)
            token_q.push_back(tok);
    endtask

    always @(posedge aclk) begin : drive_words
        word_t nxt;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready)
                tokenize_word(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    nxt      = text_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.raw;
                    s_tlast  <= nxt.eod;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b1;
            rx_mode  <= 0;
            rx_left  <= 50;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(3);
                rx_left <= $urandom_range(20, 200);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(1));
                2: m_tready <= ($urandom_range(3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    always @(posedge aclk) begin : check_tokens
        token_t got;
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{pad: m_tdata[23:18], row_ok: m_tdata[17], overflow: m_tdata[16],
                    column: m_tdata[15:9], field_end: m_tdata[8], ch: m_tdata[7:0],
                    ch_valid: m_tuser, row_end: m_tlast};
            if (token_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: data=%h user=%b last=%b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = token_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected ch=%h cv=%b fe=%b re=%b col=%0d ovf=%b rv=%b pad=%h",
                                 want.ch, want.ch_valid, want.field_end, want.row_end,
                                 want.column, want.overflow, want.row_ok, want.pad);
                        $display("          actual   ch=%h cv=%b fe=%b re=%b col=%0d ovf=%b rv=%b pad=%h",
                                 got.ch, got.ch_valid, got.field_end, got.row_end,
                                 got.column, got.overflow, got.row_ok, got.pad);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL csv_field_tokenizer");
            $finish;
        end
    end

    task automatic push_word(input logic [7:0] c, input logic eod);
        text_q.push_back('{raw: c, eod: eod});
        words_queued++;
    endtask

    task automatic push_byte(input logic [7:0] c);
        push_word(c, 1'b0);
    endtask

    task automatic push_eod();
        push_word(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] plain_byte(input bit first);
        logic [7:0] c;
        do begin
            c = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(97, 122));
        end while (c == BYTE_COMMA || c == BYTE_LF || c == BYTE_CR ||
                   (first && (c == BYTE_SPACE || c == BYTE_QUOTE)));
        return c;
    endfunction

    task automatic push_field(input int span);
        int         kind;
        int         len;
        logic [7:0] c;
        kind = $urandom_range(9);
        len  = ($urandom_range(5) == 0) ? $urandom_range(span) : $urandom_range(6);
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) push_byte(BYTE_SPACE);
        if (kind == 0)
            return;
        if (kind <= 5) begin
            for (int i = 0; i < len; i++)
                push_byte(plain_byte(i == 0));
        end else begin
            push_byte(BYTE_QUOTE);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(7))
                    0: c = BYTE_COMMA;
                    1: c = BYTE_LF;
                    2: c = BYTE_CR;
                    3: c = BYTE_QUOTE;
                    default: c = 8'($urandom_range(255));
                endcase
                push_byte(c);
                if (c == BYTE_QUOTE)
                    push_byte(BYTE_QUOTE);
            end
            push_byte(BYTE_QUOTE);
            if (kind == 9)
                push_byte(plain_byte(1'b1));
        end
    endtask

    task automatic push_row(input int cols, input int span);
        int ncols;
        bit fits;
        fits = (cols >= 1) && (cols <= MAX_COLS);
        if ($urandom_range(20) == 0)
            ncols = MAX_COLS + 2;
        else if (fits && $urandom_range(3) != 0)
            ncols = cols;
        else
            ncols = $urandom_range(1, fits ? cols + 2 : 8);
        for (int i = 0; i < ncols; i++) begin
            push_field(span);
            if ($urandom_range(15) == 0)
                push_byte(8'($urandom_range(255)));
            if ($urandom_range(30) == 0)
                push_byte(BYTE_QUOTE);
            if (i < ncols - 1)
                push_byte(BYTE_COMMA);
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: push_byte(BYTE_LF);
            6, 7: push_byte(BYTE_CR);
            8: begin
                push_byte(BYTE_CR);
                push_byte(BYTE_LF);
            end
            default: push_eod();
        endcase
    endtask

    task automatic push_rows(input int count, input int cols, input int span);
        int start;
        start = words_queued;
        while (words_queued - start < count)
            push_row(cols, span);
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (text_q.size() != 0 || s_tvalid || token_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do begin
            @(negedge aclk);
        end while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_EXPECTED_COLUMNS)
            exp_cols = value & 'h7F;
        else
            max_len = value & 'h1FFF;
    endtask

    initial begin
        int lim;
        int span;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Skipped spaces, quoted commas and newlines, a doubled quote, junk after
        // a closing quote, CR LF, an empty field, a stray quote and end of data
        // with a field open, with nothing open and inside unclosed quotes.
        push_str(" a,\"q,\"\"\n\"x\"\"\r\n,");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(BYTE_QUOTE);
        push_eod();
        push_eod();
        push_byte(BYTE_QUOTE);
        push_eod();
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(REG_EXPECTED_COLUMNS, phase_cols[p]);
            write_reg(REG_MAX_FIELD_LENGTH, phase_len[p]);
            lim  = (max_len > MAX_FIELD) ? MAX_FIELD : max_len;
            span = (lim <= 300) ? lim + 1 : 12;
            push_rows(65, exp_cols, span);
            wait_idle();
            push_rows(65, exp_cols, span);
            wait_idle();
        end

        if (mismatches == 0)
            $display("PASS csv_field_tokenizer");
        else
            $display("FAIL csv_field_tokenizer");
        $finish;
    end

endmodule
